FILE: src/searchable_stack_engine_core_assert.svh
// Assertion macros for the searchable stack engine.
// Depends on nothing; the including module provides clk_i and rst_ni.
`ifndef SEARCHABLE_STACK_ENGINE_CORE_ASSERT_SVH
`define SEARCHABLE_STACK_ENGINE_CORE_ASSERT_SVH

// Check a property at every clock edge outside reset.
`define SSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property at every clock edge, reset included.
`define SSE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: src/sse_pkg.sv
// Shared codes and field widths of the searchable stack engine.
// No dependencies; used by searchable_stack_engine_core.
package sse_pkg;

  // Operation codes
  localparam logic [2:0] OP_PUSH    = 3'd0;
  localparam logic [2:0] OP_SEARCH  = 3'd1;
  localparam logic [2:0] OP_MODIFY  = 3'd2;
  localparam logic [2:0] OP_DELETE  = 3'd3;
  localparam logic [2:0] OP_DISPLAY = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // Field widths
  localparam int unsigned OP_W    = 3;
  localparam int unsigned FIELD_W = 32;
  localparam int unsigned DEPTH_W = 4;
  localparam int unsigned IN_W    = 72;
  localparam int unsigned OUT_W   = 40;

endpackage

FILE: src/searchable_stack_engine_core.sv
// Searchable stack engine: bounded stack with push, search, modify, delete, display.
// Depends on sse_pkg and searchable_stack_engine_core_assert.svh.
//
// One operation per input transfer; the block takes a new transfer only when the
// previous one is finished, while its last result may still wait in the output
// register. Push and unused codes finish in the decode state. Search and modify scan
// entries from the top; delete then moves each entry above the hit down to close
// the gap; display reads every entry from the top. Each entry is read through the
// registered read port of the entry memory, then compared or output. Stack full,
// stack empty and key not found each give one result with tlast set.
`include "searchable_stack_engine_core_assert.svh"

module searchable_stack_engine_core #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned WORD_WIDTH  = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // tdata: operation[2:0], value[34:3], replacement[66:35], zero[71:67]
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [sse_pkg::IN_W-1:0]     s_axis_tdata_i,
  // tdata: data[31:0], depth_from_top[35:32], zero[39:36]
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [sse_pkg::OUT_W-1:0]    m_axis_tdata_o,
  // tuser: status[1:0]
  output logic [1:0]                   m_axis_tuser_o,
  output logic                         m_axis_tlast_o
);

  localparam int unsigned IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned OW = $clog2(STACK_DEPTH + 1);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_SRD  = 3'd2;
  localparam logic [2:0] S_SCMP = 3'd3;
  localparam logic [2:0] S_MRD  = 3'd4;
  localparam logic [2:0] S_MWR  = 3'd5;
  localparam logic [2:0] S_DRD  = 3'd6;
  localparam logic [2:0] S_DOUT = 3'd7;

  logic [2:0]            state_q, state_d;
  logic [2:0]            op_q, op_d;
  logic [WORD_WIDTH-1:0] key_q, key_d;
  logic [WORD_WIDTH-1:0] repl_q, repl_d;
  logic [OW-1:0]         occ_q, occ_d;
  logic [IW-1:0]         ptr_q, ptr_d;
  logic [IW-1:0]         cnt_q, cnt_d;

  // Entry memory
  logic [WORD_WIDTH-1:0] mem [STACK_DEPTH];
  logic [WORD_WIDTH-1:0] rdata_q;
  logic                  mem_we;
  logic [IW-1:0]         mem_waddr;
  logic [WORD_WIDTH-1:0] mem_wdata;
  logic [IW-1:0]         mem_raddr;

  // Output register
  logic                  out_valid_q;
  logic [1:0]            out_status_q;
  logic [31:0]           out_data_q;
  logic [3:0]            out_depth_q;
  logic                  out_last_q;
  logic                  out_free;
  logic                  emit;
  logic [1:0]            emit_status;
  logic [31:0]           emit_data;
  logic [IW-1:0]         emit_depth;
  logic                  emit_last;

  logic                  in_xfer;
  logic [WORD_WIDTH+31:0] value_ext;
  logic [WORD_WIDTH+31:0] repl_ext;
  logic [WORD_WIDTH+31:0] rdata_ext;
  logic [IW+3:0]         depth_ext;
  logic [OW-1:0]         occ_m1;
  logic [OW-1:0]         ptr_ext;
  logic [OW-1:0]         match_depth;
  logic                  hit;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  // Fit the 32-bit fields to the word width and the stored word back to 32 bits
  assign value_ext = {{WORD_WIDTH{s_axis_tdata_i[34]}}, s_axis_tdata_i[34:3]};
  assign repl_ext  = {{WORD_WIDTH{s_axis_tdata_i[66]}}, s_axis_tdata_i[66:35]};
  assign rdata_ext = {{32{rdata_q[WORD_WIDTH-1]}}, rdata_q};
  assign depth_ext = {4'b0000, emit_depth};

  assign occ_m1      = occ_q - OW'(1);
  assign ptr_ext     = OW'(ptr_q);
  assign match_depth = occ_m1 - ptr_ext;
  assign hit         = (rdata_q == key_q);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    repl_d      = repl_q;
    occ_d       = occ_q;
    ptr_d       = ptr_q;
    cnt_d       = cnt_q;
    mem_we      = 1'b0;
    mem_waddr   = ptr_q;
    mem_wdata   = rdata_q;
    mem_raddr   = ptr_q;
    emit        = 1'b0;
    emit_status = sse_pkg::ST_OK;
    emit_data   = '0;
    emit_depth  = '0;
    emit_last   = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          op_d    = s_axis_tdata_i[2:0];
          key_d   = value_ext[WORD_WIDTH-1:0];
          repl_d  = repl_ext[WORD_WIDTH-1:0];
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        ptr_d = occ_m1[IW-1:0];
        cnt_d = '0;
        if (op_q > sse_pkg::OP_DISPLAY) begin
          state_d = S_IDLE;
        end else if (op_q == sse_pkg::OP_PUSH) begin
          if (out_free) begin
            emit    = 1'b1;
            state_d = S_IDLE;
            if (occ_q == OW'(STACK_DEPTH)) begin
              emit_status = sse_pkg::ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = occ_q[IW-1:0];
              mem_wdata = key_q;
              occ_d     = occ_q + OW'(1);
            end
          end
        end else if (occ_q == '0) begin
          if (out_free) begin
            emit        = 1'b1;
            emit_status = sse_pkg::ST_EMPTY;
            state_d     = S_IDLE;
          end
        end else if (op_q == sse_pkg::OP_DISPLAY) begin
          state_d = S_DRD;
        end else begin
          state_d = S_SRD;
        end
      end
      S_SRD: begin
        state_d = S_SCMP;
      end
      S_SCMP: begin
        if (hit) begin
          if (out_free) begin
            emit       = 1'b1;
            emit_data  = rdata_ext[31:0];
            emit_depth = match_depth[IW-1:0];
            case (op_q)
              sse_pkg::OP_MODIFY: begin
                mem_we    = 1'b1;
                mem_wdata = repl_q;
                state_d   = S_IDLE;
              end
              sse_pkg::OP_DELETE: begin
                if (ptr_ext == occ_m1) begin
                  occ_d   = occ_m1;
                  state_d = S_IDLE;
                end else begin
                  state_d = S_MRD;
                end
              end
              default: state_d = S_IDLE;
            endcase
          end
        end else if (ptr_q == '0) begin
          if (out_free) begin
            emit        = 1'b1;
            emit_status = sse_pkg::ST_NOT_FOUND;
            state_d     = S_IDLE;
          end
        end else begin
          ptr_d   = ptr_q - IW'(1);
          state_d = S_SRD;
        end
      end
      // Close the gap: move each entry above the deleted one down by one
      S_MRD: begin
        mem_raddr = ptr_q + IW'(1);
        state_d   = S_MWR;
      end
      S_MWR: begin
        mem_we = 1'b1;
        ptr_d  = ptr_q + IW'(1);
        if (ptr_ext + OW'(2) == occ_q) begin
          occ_d   = occ_m1;
          state_d = S_IDLE;
        end else begin
          state_d = S_MRD;
        end
      end
      S_DRD: begin
        state_d = S_DOUT;
      end
      S_DOUT: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_data  = rdata_ext[31:0];
          emit_depth = cnt_q;
          emit_last  = (ptr_q == '0);
          if (ptr_q == '0) begin
            state_d = S_IDLE;
          end else begin
            ptr_d   = ptr_q - IW'(1);
            cnt_d   = cnt_q + IW'(1);
            state_d = S_DRD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    key_q  <= key_d;
    repl_q <= repl_d;
    ptr_q  <= ptr_d;
    cnt_q  <= cnt_d;
    if (emit) begin
      out_status_q <= emit_status;
      out_data_q   <= emit_data;
      out_depth_q  <= depth_ext[3:0];
      out_last_q   <= emit_last;
    end
  end

  // Write and read the entry memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, out_depth_q, out_data_q};
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;

  // Checks
  `SSE_ASSERT(a_occ_bound, occ_q <= OW'(STACK_DEPTH), "occupancy exceeds stack depth")
  `SSE_ASSERT(a_emit_free, emit |-> out_free, "result loaded over an untaken result")
  `SSE_ASSERT(a_occ_step, 1'b1 |=> ($stable(occ_q) || occ_q == $past(occ_q) + OW'(1) || occ_q == $past(occ_q) - OW'(1)), "occupancy moved by more than one")
  `SSE_ASSERT(a_err_last, (out_valid_q && out_status_q != sse_pkg::ST_OK) |-> out_last_q, "error result without tlast")

endmodule

FILE: bench/searchable_stack_engine_core_tb.sv
// Self-checking bench for searchable_stack_engine_core: a directed table, then random traffic.
// A local stack predictor checks every result; depends on sse_pkg and the core RTL.
`timescale 1ns / 1ps

module searchable_stack_engine_core_tb;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned ITEMS_PER_PHASE = 28;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_TYPED,
    CHK_NONE
  } check_kind_e;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] value;
    logic [31:0] repl;
    int          reps;
    check_kind_e kind;
    logic [1:0]  status;
    logic [31:0] data;
    logic [3:0]  depth;
  } stim_row_t;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] data;
    logic [3:0]  depth;
    logic        last;
  } stack_result_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       s_axis_tvalid_i;
  logic                       s_axis_tready_o;
  logic [sse_pkg::IN_W-1:0]   s_axis_tdata_i;
  logic                       m_axis_tvalid_o;
  logic                       m_axis_tready_i;
  logic [sse_pkg::OUT_W-1:0]  m_axis_tdata_o;
  logic [1:0]                 m_axis_tuser_o;
  logic                       m_axis_tlast_o;

  // Predicted stack contents, bottom at index 0
  logic [31:0]       stack_mem [STACK_DEPTH];
  int unsigned       stack_occ;
  stack_result_t     pending_results [$];
  stim_row_t         directed_tbl [$];

  int                fail_count;
  int                tx_idle_pct;
  int                rx_stall_pct;
  int                rx_hold;

  searchable_stack_engine_core #(
    .STACK_DEPTH(STACK_DEPTH),
    .WORD_WIDTH (32)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  // Clock generation
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Print one mismatch line and count it
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp);
    $display("tb: mismatch on %s: got %h, expected %h at %0t", what, got, exp, $realtime);
    fail_count++;
  endtask

  task automatic queue_result(input logic [1:0] status, input logic [31:0] data,
                              input logic [3:0] depth, input logic last);
    stack_result_t r;
    r.status = status;
    r.data   = data;
    r.depth  = depth;
    r.last   = last;
    pending_results.push_back(r);
  endtask

  // Apply one operation to the predicted stack and queue its results
  task automatic stack_apply(input logic [2:0] op, input logic [31:0] value,
                             input logic [31:0] repl);
    int idx;
    int n;
    int unsigned i;
    idx = -1;
    if (op == sse_pkg::OP_PUSH) begin
      if (stack_occ >= STACK_DEPTH) begin
        queue_result(sse_pkg::ST_FULL, '0, '0, 1'b1);
      end else begin
        stack_mem[stack_occ] = value;
        stack_occ++;
        queue_result(sse_pkg::ST_OK, '0, '0, 1'b1);
      end
    end else if (op > sse_pkg::OP_DISPLAY) begin
      // unused codes: no result, no state change
    end else if (stack_occ == 0) begin
      queue_result(sse_pkg::ST_EMPTY, '0, '0, 1'b1);
    end else if (op == sse_pkg::OP_DISPLAY) begin
      for (i = 0; i < stack_occ; i++)
        queue_result(sse_pkg::ST_OK, stack_mem[stack_occ-1-i], 4'(i),
                     (i + 1 == stack_occ));
    end else begin
      // scan from the top for the first match
      for (n = int'(stack_occ) - 1; n >= 0; n--) begin
        if (stack_mem[n] == value) begin
          idx = n;
          break;
        end
      end
      if (idx < 0) begin
        queue_result(sse_pkg::ST_NOT_FOUND, '0, '0, 1'b1);
      end else begin
        queue_result(sse_pkg::ST_OK, stack_mem[idx], 4'(int'(stack_occ) - 1 - idx), 1'b1);
        if (op == sse_pkg::OP_MODIFY) begin
          stack_mem[idx] = repl;
        end else if (op == sse_pkg::OP_DELETE) begin
          for (n = idx; n + 1 < int'(stack_occ); n++) stack_mem[n] = stack_mem[n+1];
          stack_occ--;
        end
      end
    end
  endtask

  // Offer one transfer; returns at the accepting edge with tvalid still high
  task automatic offer(input logic [2:0] op, input logic [31:0] value,
                       input logic [31:0] repl);
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {5'b0, repl, value, op};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // Predict, substitute a typed expectation where the row has one, then send
  task automatic issue(input stim_row_t r);
    int base;
    base = pending_results.size();
    stack_apply(r.op, r.value, r.repl);
    if (r.kind != CHK_MODEL) begin
      while (pending_results.size() > base) void'(pending_results.pop_back());
      if (r.kind == CHK_TYPED) queue_result(r.status, r.data, r.depth, 1'b1);
    end
    offer(r.op, r.value, r.repl);
  endtask

  function automatic stim_row_t row(input logic [2:0] op, input logic [31:0] value,
                                    input logic [31:0] repl, input int reps,
                                    input check_kind_e kind, input logic [1:0] status,
                                    input logic [31:0] data, input logic [3:0] depth);
    stim_row_t r;
    r.op     = op;
    r.value  = value;
    r.repl   = repl;
    r.reps   = reps;
    r.kind   = kind;
    r.status = status;
    r.data   = data;
    r.depth  = depth;
    return r;
  endfunction

  function automatic logic [31:0] pool_value();
    case ($urandom_range(5))
      0:       return 32'h0000_0000;
      1:       return 32'h0000_0001;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0002;
      4:       return 32'h8000_0000;
      default: return 32'h7FFF_FFFF;
    endcase
  endfunction

  // Keys mostly hit stored entries so search, modify and delete find something
  function automatic logic [31:0] pick_key();
    int unsigned r;
    r = $urandom_range(99);
    if (stack_occ > 0 && r < 50) return stack_mem[$urandom_range(stack_occ - 1)];
    else if (r < 75) return pool_value();
    else return $urandom;
  endfunction

  function automatic logic [2:0] pick_op(input bit filling);
    int unsigned r;
    r = $urandom_range(99);
    if (filling) begin
      if (r < 50)      return sse_pkg::OP_PUSH;
      else if (r < 62) return sse_pkg::OP_SEARCH;
      else if (r < 74) return sse_pkg::OP_MODIFY;
      else if (r < 84) return sse_pkg::OP_DELETE;
      else if (r < 94) return sse_pkg::OP_DISPLAY;
    end else begin
      if (r < 12)      return sse_pkg::OP_PUSH;
      else if (r < 27) return sse_pkg::OP_SEARCH;
      else if (r < 40) return sse_pkg::OP_MODIFY;
      else if (r < 85) return sse_pkg::OP_DELETE;
      else if (r < 95) return sse_pkg::OP_DISPLAY;
    end
    return 3'($urandom_range(7, 5));
  endfunction

  // Receiver: long hold-off when requested, random stalls otherwise
  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      m_axis_tready_i <= 1'b0;
      rx_hold         <= rx_hold - 1;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Compare each result transfer against the oldest expectation
  always @(posedge clk_i) begin
    stack_result_t exp_r;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata_o[31:0], '0);
      end else begin
        exp_r = pending_results.pop_front();
        if (m_axis_tuser_o != exp_r.status)
          report_mismatch("status", 32'(m_axis_tuser_o), 32'(exp_r.status));
        if (m_axis_tdata_o[31:0] != exp_r.data)
          report_mismatch("data", m_axis_tdata_o[31:0], exp_r.data);
        if (m_axis_tdata_o[35:32] != exp_r.depth)
          report_mismatch("depth_from_top", 32'(m_axis_tdata_o[35:32]), 32'(exp_r.depth));
        if (m_axis_tlast_o != exp_r.last)
          report_mismatch("last", 32'(m_axis_tlast_o), 32'(exp_r.last));
      end
    end
  end

  // Hard stop if the run hangs
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  // Main stimulus
  initial begin
    stim_row_t r;
    int phase;
    int sent;
    int n;
    int tx_pct [4];
    int rx_pct [4];
    tx_pct = '{0, 50, 0, 16};
    rx_pct = '{0, 0, 50, 16};

    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    fail_count      = 0;
    tx_idle_pct     = 0;
    rx_stall_pct    = 0;
    rx_hold         = 0;
    stack_occ       = 0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty stack, unused codes, extremes, duplicates, full stack
    directed_tbl.push_back(row(sse_pkg::OP_SEARCH,  32'h0, 32'h0, 1, CHK_TYPED,
                               sse_pkg::ST_EMPTY, '0, '0));
    directed_tbl.push_back(row(sse_pkg::OP_MODIFY,  32'h0, 32'h1, 1, CHK_TYPED,
                               sse_pkg::ST_EMPTY, '0, '0));
    directed_tbl.push_back(row(sse_pkg::OP_DELETE,  32'h0, 32'h0, 1, CHK_TYPED,
                               sse_pkg::ST_EMPTY, '0, '0));
    directed_tbl.push_back(row(sse_pkg::OP_DISPLAY, 32'h0, 32'h0, 1, CHK_TYPED,
                               sse_pkg::ST_EMPTY, '0, '0));
    directed_tbl.push_back(row(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, CHK_NONE,
                               sse_pkg::ST_OK, '0, '0));
    directed_tbl.push_back(row(3'd5, 32'h0, 32'h0, 1, CHK_NONE, sse_pkg::ST_OK, '0, '0));
    directed_tbl.push_back(row(sse_pkg::OP_PUSH, 32'h7FFF_FFFF, 32'h0, 1, CHK_TYPED,
                               sse_pkg::ST_OK, '0, '0));
    directed_tbl.push_back(row(sse_pkg::OP_PUSH, 32'h8000_0000, 32'h0, 1, CHK_TYPED,
                               sse_pkg::ST_OK, '0, '0));
    directed_tbl.push_back(row(sse_pkg::OP_PUSH, 32'h0000_0000, 32'h0, 1, CHK_TYPED,
                               sse_pkg::ST_OK, '0, '0));
    directed_tbl.push_back(row(sse_pkg::OP_PUSH, 32'hFFFF_FFFF, 32'h0, 1, CHK_TYPED,
                               sse_pkg::ST_OK, '0, '0));
    directed_tbl.push_back(row(sse_pkg::OP_SEARCH, 32'h8000_0000, 32'h0, 1, CHK_TYPED,
                               sse_pkg::ST_OK, 32'h8000_0000, 4'd2));
    directed_tbl.push_back(row(sse_pkg::OP_SEARCH, 32'h1234_5678, 32'h0, 1, CHK_TYPED,
                               sse_pkg::ST_NOT_FOUND, '0, '0));
    directed_tbl.push_back(row(sse_pkg::OP_MODIFY, 32'h0, 32'hFFFF_FFFF, 1, CHK_MODEL,
                               sse_pkg::ST_OK, '0, '0));
    directed_tbl.push_back(row(sse_pkg::OP_SEARCH, 32'hFFFF_FFFF, 32'h0, 1, CHK_MODEL,
                               sse_pkg::ST_OK, '0, '0));
    directed_tbl.push_back(row(sse_pkg::OP_DELETE, 32'hFFFF_FFFF, 32'h0, 1, CHK_MODEL,
                               sse_pkg::ST_OK, '0, '0));
    directed_tbl.push_back(row(sse_pkg::OP_SEARCH, 32'hFFFF_FFFF, 32'h0, 1, CHK_MODEL,
                               sse_pkg::ST_OK, '0, '0));
    directed_tbl.push_back(row(sse_pkg::OP_DELETE, 32'h7FFF_FFFF, 32'h0, 1, CHK_MODEL,
                               sse_pkg::ST_OK, '0, '0));
    directed_tbl.push_back(row(sse_pkg::OP_DISPLAY, 32'h0, 32'h0, 1, CHK_MODEL,
                               sse_pkg::ST_OK, '0, '0));
    directed_tbl.push_back(row(sse_pkg::OP_PUSH, 32'hA5A5_A5A5, 32'h0, 14, CHK_MODEL,
                               sse_pkg::ST_OK, '0, '0));
    directed_tbl.push_back(row(sse_pkg::OP_PUSH, 32'h5A5A_5A5A, 32'h0, 1, CHK_TYPED,
                               sse_pkg::ST_FULL, '0, '0));
    directed_tbl.push_back(row(sse_pkg::OP_PUSH, 32'h0, 32'h0, 1, CHK_TYPED,
                               sse_pkg::ST_FULL, '0, '0));
    directed_tbl.push_back(row(sse_pkg::OP_DISPLAY, 32'h0, 32'h0, 1, CHK_MODEL,
                               sse_pkg::ST_OK, '0, '0));
    directed_tbl.push_back(row(sse_pkg::OP_DELETE, 32'h8000_0000, 32'h0, 1, CHK_MODEL,
                               sse_pkg::ST_OK, '0, '0));
    directed_tbl.push_back(row(sse_pkg::OP_DELETE, 32'hA5A5_A5A5, 32'h0, 1, CHK_MODEL,
                               sse_pkg::ST_OK, '0, '0));
    directed_tbl.push_back(row(sse_pkg::OP_MODIFY, 32'h5A5A_5A5A, 32'h1, 1, CHK_TYPED,
                               sse_pkg::ST_NOT_FOUND, '0, '0));

    // Walk the directed table with no idling
    @(posedge clk_i);
    foreach (directed_tbl[i]) begin
      for (n = 0; n < directed_tbl[i].reps; n++) issue(directed_tbl[i]);
    end
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);

    // Random phases: none, sender idle, receiver stall, both
    for (phase = 0; phase < 4; phase++) begin
      tx_idle_pct  = tx_pct[phase];
      rx_stall_pct = rx_pct[phase];
      // long receiver hold-off while the sender keeps offering
      if (phase == 2) rx_hold = 400;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        r = row(pick_op(((sent / 12) % 2) == 0), '0, '0, 1, CHK_MODEL,
                sse_pkg::ST_OK, '0, '0);
        r.value = (r.op == sse_pkg::OP_PUSH && $urandom_range(1)) ? pool_value()
                                                                  : pick_key();
        r.repl  = $urandom_range(1) ? pool_value() : 32'($urandom);
        issue(r);
        if (r.op <= sse_pkg::OP_DISPLAY) sent++;
      end
      // pause the sender until every expected result has arrived
      s_axis_tvalid_i <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk_i);
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/sse_pkg.sv
src/searchable_stack_engine_core.sv
bench/searchable_stack_engine_core_tb.sv
